@@ sv/dtbl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtbl_pkg
// shared types and constants of the dated two-bank write-once log
// ----------------------------------------------------------------------------
package dtbl_pkg;

    localparam int unsigned TAG_W   = 32;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned INDEX_W = 9;
    localparam int unsigned ENTRY_W = WORD_W + 1;   // written flag + word

    localparam logic [TAG_W-1:0]  TAG_ERASED  = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_ERASED = 16'hFFFF;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_WRITTEN   = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_SAVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_ERASE,
        ST_RESP
    } state_t;

    // result handed from the controller to the output register
    typedef struct packed {
        logic              load;
        logic [WORD_W-1:0] read_value;
        logic [1:0]        status;
    } result_t;

endpackage

`default_nettype wire

@@ sv/dated_two_bank_write_once_log.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dated_two_bank_write_once_log
// two date-tagged banks of write-once 16-bit points
// ----------------------------------------------------------------------------
// Each item is a read or a save of one numbered point under a date key
// {year, month, day}. The accept cycle picks the bank from the two tag
// registers and reads the point's entry from the single-port word store;
// the response state then checks the written flag, writes the word back on
// a save and loads the result register. A save that finds neither bank usable
// erases the bank with the older tag first, one entry per cycle. After reset
// all 2 * POINTS_PER_BANK entries of the store are cleared while in_stall is
// high. The result sits in an output register, so a new item is accepted
// while a result still waits; that item completes once the output register
// is free again.
// ----------------------------------------------------------------------------
module dated_two_bank_write_once_log
    import dtbl_pkg::*;
#(
    parameter int unsigned POINTS_PER_BANK = 255
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [15:0] year,
    input  wire logic [7:0]  month,
    input  wire logic [7:0]  day,
    input  wire logic [8:0]  point_index,
    input  wire logic [15:0] point_value,
    // result items
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [15:0] read_value,
    output logic      [1:0]  status
);

    // both banks share one store, bank 1 above bank 0
    localparam int unsigned DEPTH = 2 * POINTS_PER_BANK;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  read_value_reg;
    logic [1:0]         status_reg;
    logic               out_free;
    result_t            result;

    logic               mem_en;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    // output register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    dtbl_ctrl #(
        .POINTS_PER_BANK (POINTS_PER_BANK),
        .AW              (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .year        (year),
        .month       (month),
        .day         (day),
        .point_index (point_index),
        .point_value (point_value),
        .out_free    (out_free),
        .result      (result),
        .mem_en      (mem_en),
        .mem_we      (mem_we),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .mem_rdata   (mem_rdata)
    );

    dtbl_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // output valid: set on a load, cleared once the item is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (result.load)
        begin
            read_value_reg <= result.read_value;
            status_reg     <= result.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

@@ sv/dtbl_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtbl_mem
// single-port word store, one access a cycle, registered read data
// ----------------------------------------------------------------------------
module dtbl_mem
    import dtbl_pkg::*;
#(
    parameter int unsigned DEPTH = 510,
    parameter int unsigned AW    = 9
)
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic               we,
    input  wire logic [AW-1:0]      addr,
    input  wire logic [ENTRY_W-1:0] wdata,
    output logic      [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem_array [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_array[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_array[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/dtbl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtbl_ctrl
// bank tags, bank selection and the read-modify-write sequencer
// ----------------------------------------------------------------------------
module dtbl_ctrl
    import dtbl_pkg::*;
#(
    parameter int unsigned POINTS_PER_BANK = 255,
    parameter int unsigned AW              = 9
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               command,
    input  wire logic [15:0]        year,
    input  wire logic [7:0]         month,
    input  wire logic [7:0]         day,
    input  wire logic [INDEX_W-1:0] point_index,
    input  wire logic [WORD_W-1:0]  point_value,
    input  wire logic               out_free,
    output result_t                 result,
    output logic                    mem_en,
    output logic                    mem_we,
    output logic      [AW-1:0]      mem_addr,
    output logic      [ENTRY_W-1:0] mem_wdata,
    input  wire logic [ENTRY_W-1:0] mem_rdata
);

    localparam logic [INDEX_W-1:0] P_IDX    = INDEX_W'(POINTS_PER_BANK);
    localparam logic [AW-1:0]      BANK1    = AW'(POINTS_PER_BANK);
    localparam logic [AW-1:0]      LAST_ALL = AW'(2 * POINTS_PER_BANK - 1);
    localparam logic [AW-1:0]      LAST_ONE = AW'(POINTS_PER_BANK - 1);

    state_t state_reg, state_next;
    logic [AW-1:0]     off_reg, off_next;
    logic [TAG_W-1:0]  tag0_reg, tag0_next;
    logic [TAG_W-1:0]  tag1_reg, tag1_next;

    // item held over the sequence
    logic              cmd_reg, cmd_next;
    logic              bank_reg, bank_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic              bad_reg, bad_next;
    logic              nomatch_reg, nomatch_next;
    logic              fresh_reg, fresh_next;

    logic              accept;
    logic [TAG_W-1:0]  key;
    logic              idx_ok;
    logic              m0, m1, e0, e1;
    logic              sel_bank;
    logic              need_erase;
    logic [AW-1:0]     item_addr;
    logic [AW-1:0]     erase_base;
    logic              off_last;
    logic              word_written;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign key      = {year, month, day};
    assign idx_ok   = (point_index != '0) && (point_index <= P_IDX);
    assign m0       = (tag0_reg == key);
    assign m1       = (tag1_reg == key);
    assign e0       = (tag0_reg == TAG_ERASED);
    assign e1       = (tag1_reg == TAG_ERASED);

    // bank choice: reads take the first match, saves follow the fill order
    always_comb
    begin
        need_erase = 1'b0;
        if (command == CMD_READ)
        begin
            sel_bank = !m0;
        end
        else
        begin
            priority if (m0 || e0)
            begin
                sel_bank = 1'b0;
            end
            else if (m1 || e1)
            begin
                sel_bank = 1'b1;
            end
            else
            begin
                // older date goes, bank 1 on a tie
                sel_bank   = !(tag0_reg < tag1_reg);
                need_erase = 1'b1;
            end
        end
    end

    assign item_addr  = (sel_bank ? BANK1 : '0) + AW'(point_index - INDEX_W'(1));
    assign erase_base = bank_reg ? BANK1 : '0;
    assign off_last   = (state_reg == ST_INIT) ? (off_reg == LAST_ALL)
                                               : (off_reg == LAST_ONE);
    assign word_written = mem_rdata[ENTRY_W-1] && !fresh_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (off_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (command == CMD_SAVE && idx_ok && need_erase)
                                 ? ST_ERASE : ST_RESP;
                end
            end
            ST_ERASE:
            begin
                if (off_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // outputs: handshake, memory port, result
    always_comb
    begin
        in_stall          = (state_reg != ST_IDLE);
        mem_en            = 1'b0;
        mem_we            = 1'b0;
        mem_addr          = addr_reg;
        mem_wdata         = {1'b1, value_reg};
        result.load       = 1'b0;
        result.read_value = WORD_ERASED;
        result.status     = STATUS_OK;
        unique case (state_reg)
            ST_INIT:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = off_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                mem_addr = item_addr;
                mem_en   = in_valid && idx_ok
                           && !(command == CMD_READ && !m0 && !m1)
                           && !(command == CMD_SAVE && need_erase);
            end
            ST_ERASE:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = erase_base + off_reg;
                mem_wdata = '0;
            end
            ST_RESP:
            begin
                result.load = out_free;
                if (cmd_reg == CMD_READ)
                begin
                    if (bad_reg)
                    begin
                        result.status = STATUS_BAD_INDEX;
                    end
                    else if (!nomatch_reg && mem_rdata[ENTRY_W-1])
                    begin
                        result.read_value = mem_rdata[WORD_W-1:0];
                    end
                end
                else
                begin
                    result.read_value = '0;
                    if (bad_reg)
                    begin
                        result.status = STATUS_BAD_INDEX;
                    end
                    else if (word_written)
                    begin
                        result.status = STATUS_WRITTEN;
                    end
                    else
                    begin
                        mem_en = out_free;
                        mem_we = out_free;
                    end
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // register next values
    always_comb
    begin
        off_next     = off_reg;
        tag0_next    = tag0_reg;
        tag1_next    = tag1_reg;
        cmd_next     = cmd_reg;
        bank_next    = bank_reg;
        addr_next    = addr_reg;
        value_next   = value_reg;
        bad_next     = bad_reg;
        nomatch_next = nomatch_reg;
        fresh_next   = fresh_reg;

        if (state_reg == ST_INIT || state_reg == ST_ERASE)
        begin
            off_next = off_last ? '0 : off_reg + AW'(1);
        end

        if (accept)
        begin
            cmd_next     = command;
            bank_next    = sel_bank;
            addr_next    = item_addr;
            value_next   = point_value;
            bad_next     = !idx_ok;
            nomatch_next = !m0 && !m1;
            fresh_next   = need_erase;
            // a save takes over an erased bank or the erased victim
            if (command == CMD_SAVE && idx_ok)
            begin
                if (!sel_bank && !m0)
                begin
                    tag0_next = key;
                end
                if (sel_bank && !m1)
                begin
                    tag1_next = key;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            off_reg   <= '0;
            tag0_reg  <= TAG_ERASED;
            tag1_reg  <= TAG_ERASED;
        end
        else
        begin
            state_reg <= state_next;
            off_reg   <= off_next;
            tag0_reg  <= tag0_next;
            tag1_reg  <= tag1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        bank_reg    <= bank_next;
        addr_reg    <= addr_next;
        value_reg   <= value_next;
        bad_reg     <= bad_next;
        nomatch_reg <= nomatch_next;
        fresh_reg   <= fresh_next;
    end

endmodule

`default_nettype wire

@@ bench/dtbl_log_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtbl_log_checker
// watches both channels of the dated two-bank log and checks every result
// ----------------------------------------------------------------------------
// Keeps its own copy of the bank tags and word store. Each accepted input
// item is run through that copy, and the answer is queued. Each accepted
// result item is compared field by field with the oldest queued answer.
// ----------------------------------------------------------------------------
module dtbl_log_checker
    import dtbl_pkg::*;
#(
    parameter int unsigned POINTS_PER_BANK = 255
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic              command,
    input  wire logic [15:0]       year,
    input  wire logic [7:0]        month,
    input  wire logic [7:0]        day,
    input  wire logic [8:0]        point_index,
    input  wire logic [15:0]       point_value,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic [15:0]       read_value,
    input  wire logic [1:0]        status,
    output int unsigned            failures,
    output int unsigned            waiting
);

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic [1:0]        status;
    } answer_t;

    logic [TAG_W-1:0]  tag_of     [2];
    logic              written_of [2][POINTS_PER_BANK];
    logic [WORD_W-1:0] word_of    [2][POINTS_PER_BANK];
    answer_t           answers_due [$];

    // applies one read or save to the bank copy and returns its answer
    function automatic answer_t log_access(input logic cmd, input logic [TAG_W-1:0] key,
                                           input logic [INDEX_W-1:0] idx,
                                           input logic [WORD_W-1:0] value);
        answer_t answer;
        logic    index_ok;
        int      slot;
        int      bank;
        int      i;
        index_ok = (idx >= 1) && (idx <= POINTS_PER_BANK);
        slot = index_ok ? int'(idx) - 1 : 0;
        answer.read_value = (cmd == CMD_READ) ? WORD_ERASED : '0;
        answer.status = STATUS_OK;
        if (!index_ok) begin
            answer.status = STATUS_BAD_INDEX;
        end else if (cmd == CMD_READ) begin
            bank = (tag_of[0] == key) ? 0 : (tag_of[1] == key) ? 1 : -1;
            if (bank >= 0 && written_of[bank][slot])
                answer.read_value = word_of[bank][slot];
        end else begin
            if (tag_of[0] == key) begin
                bank = 0;
            end else if (tag_of[0] == TAG_ERASED) begin
                bank = 0;
                tag_of[0] = key;
            end else if (tag_of[1] == key) begin
                bank = 1;
            end else if (tag_of[1] == TAG_ERASED) begin
                bank = 1;
                tag_of[1] = key;
            end else begin
                // older date loses its bank, bank 1 on a tie
                bank = (tag_of[0] < tag_of[1]) ? 0 : 1;
                for (i = 0; i < POINTS_PER_BANK; i++)
                    written_of[bank][i] = 1'b0;
                tag_of[bank] = key;
            end
            if (written_of[bank][slot]) begin
                answer.status = STATUS_WRITTEN;
            end else begin
                written_of[bank][slot] = 1'b1;
                word_of[bank][slot] = value;
            end
        end
        return answer;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_of[0] = TAG_ERASED;
            tag_of[1] = TAG_ERASED;
            for (int b = 0; b < 2; b++)
                for (int i = 0; i < POINTS_PER_BANK; i++)
                    written_of[b][i] = 1'b0;
            answers_due.delete();
            failures = 0;
            waiting = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result item with no answer due: read_value %h, status %0d",
                           read_value, status);
                    failures++;
                end
                else
                begin
                    answer_t due;
                    due = answers_due.pop_front();
                    if (read_value !== due.read_value)
                    begin
                        $error("read_value: expected %h, got %h", due.read_value, read_value);
                        failures++;
                    end
                    if (status !== due.status)
                    begin
                        $error("status: expected %0d, got %0d", due.status, status);
                        failures++;
                    end
                end
            end
            if (in_valid && !in_stall)
                answers_due.push_back(log_access(command, {year, month, day},
                                                 point_index, point_value));
            waiting = answers_due.size();
        end
    end

endmodule

@@ bench/dated_two_bank_write_once_log_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dated_two_bank_write_once_log_test
// stimulus and verdict for the dated two-bank write-once log
// ----------------------------------------------------------------------------
// A short directed run walks through bad indexes, repeated saves, reads with
// no matching date, bank erases and the all-ones date. A long random run then
// draws dates from a small pool so that banks are matched, taken and erased
// over and over, with most indexes kept low so words get read back and saved
// twice. Both channels idle at random; a checker beside the block does the
// predicting and comparing.
// ----------------------------------------------------------------------------
module dated_two_bank_write_once_log_test
    import dtbl_pkg::*;
();

    localparam int unsigned POINTS       = 255;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned BLOCK_ITEMS  = 100;   // idling mode and date pool change per block
    localparam int unsigned POOL_SIZE    = 3;     // three dates for two banks forces erases

    // a few fixed dates, in rising order so the erase choice is known
    localparam logic [TAG_W-1:0] DATE_A    = {16'd2024, 8'd1, 8'd1};
    localparam logic [TAG_W-1:0] DATE_B    = {16'd2024, 8'd1, 8'd2};
    localparam logic [TAG_W-1:0] DATE_C    = {16'd2024, 8'd1, 8'd3};
    localparam logic [TAG_W-1:0] DATE_ZERO = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = CMD_READ;
    logic [15:0] year = '0;
    logic [7:0]  month = '0;
    logic [7:0]  day = '0;
    logic [8:0]  point_index = '0;
    logic [15:0] point_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] read_value;
    logic [1:0]  status;

    int unsigned failures;
    int unsigned waiting;

    // longest idle gap each side may draw; zero gives a stretch with no idling
    int unsigned in_gap_max = 10;
    int unsigned out_stall_max = 10;
    int unsigned out_hold = 0;
    int unsigned out_pause;

    logic [TAG_W-1:0] date_pool [POOL_SIZE];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    dated_two_bank_write_once_log #(
        .POINTS_PER_BANK (POINTS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .year        (year),
        .month       (month),
        .day         (day),
        .point_index (point_index),
        .point_value (point_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .status      (status)
    );

    dtbl_log_checker #(
        .POINTS_PER_BANK (POINTS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .year        (year),
        .month       (month),
        .day         (day),
        .point_index (point_index),
        .point_value (point_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .status      (status),
        .failures    (failures),
        .waiting     (waiting)
    );

    // result side: after each accepted result, stall for a freshly drawn
    // number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            out_pause = $urandom_range(out_stall_max, 0);
            out_hold <= out_pause;
            out_stall <= (out_pause != 0);
        end
        else if (out_hold != 0)
        begin
            out_hold <= out_hold - 1;
            out_stall <= (out_hold > 1);
        end
    end

    // one item onto the input channel; called at a rising edge and returns at
    // the edge that accepts it, so back-to-back items keep valid high
    task automatic send_access(input logic cmd, input logic [TAG_W-1:0] date,
                               input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] value);
        int unsigned gap;
        gap = $urandom_range(in_gap_max, 0);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        year <= date[31:16];
        month <= date[15:8];
        day <= date[7:0];
        point_index <= idx;
        point_value <= value;
        // in_stall read here still holds its value from before the edge
        do @(posedge clk); while (in_stall);
    endtask

    // new set of dates for the next block, now and then the all-ones date
    task automatic refresh_dates();
        for (int i = 0; i < POOL_SIZE; i++)
            date_pool[i] = ($urandom_range(7, 0) == 0) ? TAG_ERASED : TAG_W'($urandom);
    endtask

    initial
    begin
        logic [TAG_W-1:0]   date;
        logic [INDEX_W-1:0] idx;
        int unsigned        pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // the block clears its store after reset; in_stall holds items off meanwhile

        // bad indexes and a read before anything is saved
        send_access(CMD_READ, DATE_A, 9'd1,   16'h0000);
        send_access(CMD_SAVE, DATE_A, 9'd0,   16'h1111);
        send_access(CMD_SAVE, DATE_A, 9'd256, 16'h2222);
        send_access(CMD_SAVE, DATE_A, 9'd511, 16'hFFFF);
        send_access(CMD_READ, DATE_A, 9'd0,   16'h0000);
        send_access(CMD_READ, DATE_A, 9'd511, 16'hFFFF);
        // bank 0 takes the first date, then a second save of the same word
        send_access(CMD_SAVE, DATE_A, 9'd1,   16'h1234);
        send_access(CMD_SAVE, DATE_A, 9'd1,   16'hBEEF);
        send_access(CMD_READ, DATE_A, 9'd1,   16'h0000);
        // last point: unwritten, then written with an all-ones word
        send_access(CMD_READ, DATE_A, 9'd255, 16'h0000);
        send_access(CMD_SAVE, DATE_A, 9'd255, 16'hFFFF);
        send_access(CMD_READ, DATE_A, 9'd255, 16'h0000);
        // bank 1 takes the second date
        send_access(CMD_SAVE, DATE_B, 9'd255, 16'h0000);
        send_access(CMD_READ, DATE_B, 9'd255, 16'hFFFF);
        // third date: the bank holding the older date is erased
        send_access(CMD_SAVE, DATE_C, 9'd1,   16'h5A5A);
        send_access(CMD_READ, DATE_A, 9'd1,   16'h0000);
        send_access(CMD_READ, DATE_C, 9'd2,   16'h0000);
        // all-ones date erases the other bank and leaves its tag looking erased
        send_access(CMD_SAVE, TAG_ERASED, 9'd3, 16'hA5A5);
        send_access(CMD_READ, TAG_ERASED, 9'd3, 16'h0000);
        // so the next new date claims that bank with its word still written
        send_access(CMD_SAVE, DATE_ZERO, 9'd3,   16'h0001);
        send_access(CMD_READ, DATE_ZERO, 9'd3,   16'h0000);
        send_access(CMD_SAVE, DATE_ZERO, 9'd255, 16'h8000);
        send_access(CMD_READ, DATE_C,    9'd1,   16'h0000);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % BLOCK_ITEMS == 0)
            begin
                refresh_dates();
                // each side idles or runs flat out, independently per block
                in_gap_max = $urandom_range(1, 0) ? 10 : 0;
                out_stall_max = $urandom_range(1, 0) ? 10 : 0;
            end
            // mostly pool dates so banks are matched; some strays force erases
            date = ($urandom_range(9, 0) == 0) ? TAG_W'($urandom)
                                                : date_pool[$urandom_range(POOL_SIZE - 1, 0)];
            pick = $urandom_range(99, 0);
            if (pick < 70)
                idx = INDEX_W'($urandom_range(16, 1));
            else if (pick < 88)
                idx = INDEX_W'($urandom_range(POINTS, 1));
            else
                idx = INDEX_W'($urandom_range(511, 0));
            send_access($urandom_range(1, 0) ? CMD_SAVE : CMD_READ, date, idx,
                        WORD_W'($urandom));
        end
        in_valid <= 1'b0;

        // sample the checker's count away from the rising edge
        do @(negedge clk); while (waiting != 0);
        repeat (20) @(posedge clk);

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // worst case is far below this: ~1000 items, each with a full bank erase
    // and both idle gaps at their longest, plus the clearing pass
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/dtbl_pkg.sv
sv/dtbl_mem.sv
sv/dtbl_ctrl.sv
sv/dated_two_bank_write_once_log.sv
bench/dtbl_log_checker.sv
bench/dated_two_bank_write_once_log_test.sv
